// ===== rtl/rgbs_pkg.sv =====
// Package: types, codes and reset values for the RGB and breathing LED sweeper.
package rgbs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DWELL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_DWELL   = 3'd4;

    localparam logic [7:0]  RST_BRIGHT_LIMIT = 8'h60;
    localparam logic [7:0]  RST_DIM_LIMIT    = 8'hEF;
    localparam logic [7:0]  RST_PRESCALE     = 8'd3;
    localparam logic [15:0] RST_SLOW_DWELL   = 16'd10000;
    localparam logic [15:0] RST_FAST_DWELL   = 16'd200;

    localparam logic [7:0] LEVEL_OFF  = 8'hFF;
    localparam logic [7:0] LEVEL_FULL = 8'h00;

    localparam logic [1:0] COL_R = 2'd0;
    localparam logic [1:0] COL_G = 2'd1;
    localparam logic [1:0] COL_B = 2'd2;

    typedef enum logic [1:0] {
        MODE_FADE_SLOW = 2'd0,
        MODE_FADE_FAST = 2'd1,
        MODE_POTS      = 2'd2,
        MODE_POT_WHITE = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0]  bright_limit;
        logic [7:0]  dim_limit;
        logic [7:0]  prescale;
        logic [15:0] slow_dwell_us;
        logic [15:0] fast_dwell_us;
    } t_cfg;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] lvl_r;
        logic [7:0] lvl_g;
        logic [7:0] lvl_b;
        logic [2:0] falling;
        logic [2:0] rising;
        logic [7:0] breath_level;
        logic       going_bright;
        logic [7:0] prescale_count;
        logic [7:0] duty_w;
        logic [7:0] duty_r;
        logic [7:0] duty_g;
        logic [7:0] duty_b;
    } t_state;

    typedef struct packed {
        logic       mode_press;
        logic [7:0] pot_red;
        logic [7:0] pot_green;
        logic [7:0] pot_blue;
        logic [7:0] pot_system;
    } t_item;

    typedef struct packed {
        logic [7:0]  white_duty;
        logic [7:0]  red_duty;
        logic [7:0]  green_duty;
        logic [7:0]  blue_duty;
        logic [1:0]  mode_now;
        logic [15:0] dwell_us;
    } t_result;

endpackage

// ===== rtl/rgbs_in_if.sv =====
// Interface: input tick channel with valid/ready handshake.
interface rgbs_in_if;
    logic            valid;
    logic            ready;
    rgbs_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rgbs_out_if.sv =====
// Interface: result channel with valid/ready handshake.
interface rgbs_out_if;
    logic              valid;
    logic              ready;
    rgbs_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rgbs_step.sv =====
// Step logic: next state and result for one tick.
module rgbs_step (
    input  rgbs_pkg::t_cfg    i_cfg,
    input  rgbs_pkg::t_state  i_state,
    input  rgbs_pkg::t_item   i_item,
    output rgbs_pkg::t_state  o_state,
    output rgbs_pkg::t_result o_result
);
    import rgbs_pkg::*;

    t_state wheel_s;
    t_state breath_s;
    logic [7:0] lr, lg, lb;
    logic [2:0] fl, rs;

    // colour wheel: down blocks then up blocks, in order
    always_comb begin
        lr = i_state.lvl_r;
        lg = i_state.lvl_g;
        lb = i_state.lvl_b;
        fl = i_state.falling;
        rs = i_state.rising;
        if (fl[COL_R]) begin
            lr = lr - 8'd1;
            if (lr == LEVEL_FULL) begin
                fl[COL_R] = 1'b0;
                fl[COL_G] = 1'b1;
                rs[COL_B] = 1'b1;
            end
        end
        if (fl[COL_G]) begin
            lg = lg - 8'd1;
            if (lg == LEVEL_FULL) begin
                fl[COL_G] = 1'b0;
                fl[COL_B] = 1'b1;
                rs[COL_R] = 1'b1;
            end
        end
        if (fl[COL_B]) begin
            lb = lb - 8'd1;
            if (lb == LEVEL_FULL) begin
                fl[COL_B] = 1'b0;
                fl[COL_R] = 1'b1;
                rs[COL_G] = 1'b1;
            end
        end
        if (rs[COL_R]) begin
            lr = lr + 8'd1;
            if (lr == LEVEL_OFF) begin
                rs[COL_R] = 1'b0;
                rs[COL_G] = 1'b1;
            end
        end
        if (rs[COL_G]) begin
            lg = lg + 8'd1;
            if (lg == LEVEL_OFF) begin
                rs[COL_G] = 1'b0;
                rs[COL_B] = 1'b1;
            end
        end
        if (rs[COL_B]) begin
            lb = lb + 8'd1;
            if (lb == LEVEL_OFF) begin
                rs[COL_B] = 1'b0;
                rs[COL_R] = 1'b1;
            end
        end
        wheel_s         = i_state;
        wheel_s.lvl_r   = lr;
        wheel_s.lvl_g   = lg;
        wheel_s.lvl_b   = lb;
        wheel_s.falling = fl;
        wheel_s.rising  = rs;
        wheel_s.duty_r  = lr;
        wheel_s.duty_g  = lg;
        wheel_s.duty_b  = lb;
    end

    // breathing fade applied on top of the wheel result
    always_comb begin
        breath_s = wheel_s;
        if (i_state.prescale_count >= i_cfg.prescale) begin
            breath_s.prescale_count = 8'd0;
            if (i_state.going_bright) begin
                breath_s.breath_level = i_state.breath_level - 8'd1;
                if (breath_s.breath_level <= i_cfg.bright_limit) begin
                    breath_s.breath_level = i_cfg.bright_limit;
                    breath_s.going_bright = 1'b0;
                end
            end else begin
                breath_s.breath_level = i_state.breath_level + 8'd1;
                if (breath_s.breath_level >= i_cfg.dim_limit) begin
                    breath_s.breath_level = i_cfg.dim_limit;
                    breath_s.going_bright = 1'b1;
                end
            end
            breath_s.duty_w = breath_s.breath_level;
        end else begin
            breath_s.prescale_count = i_state.prescale_count + 8'd1;
        end
    end

    always_comb begin
        o_state           = i_state;
        o_result.dwell_us = i_cfg.slow_dwell_us;
        case (i_state.mode)
            MODE_FADE_SLOW: begin
                o_state = breath_s;
            end
            MODE_FADE_FAST: begin
                o_state           = breath_s;
                o_result.dwell_us = i_cfg.fast_dwell_us;
            end
            MODE_POTS: begin
                o_state.duty_w = i_item.pot_system;
                o_state.duty_r = i_item.pot_red;
                o_state.duty_g = i_item.pot_green;
                o_state.duty_b = i_item.pot_blue;
            end
            MODE_POT_WHITE: begin
                o_state        = wheel_s;
                o_state.duty_w = i_item.pot_system;
            end
            default: begin
                o_state = i_state;
            end
        endcase
        if (i_item.mode_press) begin
            o_state.mode = t_mode'(i_state.mode + 2'd1);
        end
        o_result.white_duty = o_state.duty_w;
        o_result.red_duty   = o_state.duty_r;
        o_result.green_duty = o_state.duty_g;
        o_result.blue_duty  = o_state.duty_b;
        o_result.mode_now   = o_state.mode;
    end

endmodule

// ===== rtl/rgb_and_breathing_led_sweeper.sv =====
// Top level: RGB colour-wheel and white breathing LED sweeper.
//
// Usage:
//   i_in carries one tick per beat: the mode-button flag and four pot
//   readings. o_out returns one result beat per tick: white, red, green and
//   blue compare values (255 off, 0 full on), the mode after the button
//   handling and the dwell time before the next tick.
//   The configuration port writes limits, prescale and dwell times at
//   i_cfg_idx when i_cfg_we is high; write it only while no tick is pending.
//   A tick's result is registered (in the skid entry while o_out stalls).
//   Throughput: one tick per cycle while i_in.ready is high, set by the
//   single-pass step logic between the state and the result registers.
//   The result register is backed by one skid entry, so a tick is still
//   taken while a finished result waits; i_in.ready drops only when both
//   hold results, and everything holds until o_out.ready returns.
//   Reset (synchronous, active low) restores register defaults, mode 0,
//   all levels and duties to 255 and empties the output stages.
module rgb_and_breathing_led_sweeper (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rgbs_in_if.sink                        i_in,
    rgbs_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [rgbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rgbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rgbs_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state, n_state;
    t_result step_res;
    logic    r_out_valid, n_out_valid;
    t_result r_out_data, n_out_data;
    logic    r_skid_valid, n_skid_valid;
    t_result r_skid_data, n_skid_data;
    logic    accept;
    logic    out_free;

    rgbs_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (i_in.data),
        .o_state  (n_state),
        .o_result (step_res)
    );

    assign i_in.ready  = !r_skid_valid;
    assign accept      = i_in.valid && !r_skid_valid;
    assign out_free    = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bright_limit  <= RST_BRIGHT_LIMIT;
            r_cfg.dim_limit     <= RST_DIM_LIMIT;
            r_cfg.prescale      <= RST_PRESCALE;
            r_cfg.slow_dwell_us <= RST_SLOW_DWELL;
            r_cfg.fast_dwell_us <= RST_FAST_DWELL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BRIGHT_LIMIT: r_cfg.bright_limit  <= i_cfg_data[7:0];
                CFG_DIM_LIMIT:    r_cfg.dim_limit     <= i_cfg_data[7:0];
                CFG_PRESCALE:     r_cfg.prescale      <= i_cfg_data[7:0];
                CFG_SLOW_DWELL:   r_cfg.slow_dwell_us <= i_cfg_data;
                CFG_FAST_DWELL:   r_cfg.fast_dwell_us <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode           <= MODE_FADE_SLOW;
            r_state.lvl_r          <= LEVEL_OFF;
            r_state.lvl_g          <= LEVEL_OFF;
            r_state.lvl_b          <= LEVEL_OFF;
            r_state.falling        <= 3'b001;
            r_state.rising         <= 3'b100;
            r_state.breath_level   <= LEVEL_OFF;
            r_state.going_bright   <= 1'b1;
            r_state.prescale_count <= 8'd0;
            r_state.duty_w         <= LEVEL_OFF;
            r_state.duty_r         <= LEVEL_OFF;
            r_state.duty_g         <= LEVEL_OFF;
            r_state.duty_b         <= LEVEL_OFF;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // result register with one skid entry
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = accept;
                n_out_data  = step_res;
            end
        end else if (accept) begin
            n_skid_valid = 1'b1;
            n_skid_data  = step_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

endmodule

// ===== rtl/rgbs_checker.sv =====
// Checker: port-level assertions for the sweeper, bound to the top level.
module rgbs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input rgbs_pkg::t_result i_out_data
);
    import rgbs_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted tick left no result");

    a_full_only_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input blocked with no result pending");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

endmodule

bind rgb_and_breathing_led_sweeper rgbs_checker u_rgbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ===== bench/rgbs_sweep_checker.sv =====
// Checker: predicts every sweeper result from the accepted ticks and compares each result beat.
`timescale 1ns / 100ps
module rgbs_sweep_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tick_valid,
    input  logic                            i_tick_ready,
    input  rgbs_pkg::t_item                 i_tick,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  rgbs_pkg::t_result               i_res,
    input  logic                            i_cfg_we,
    input  logic [rgbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rgbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);
    import rgbs_pkg::*;

    t_cfg       cfg_q;
    t_mode      mode_q;
    logic [7:0] wheel_lvl [3];
    logic [2:0] fall_q;
    logic [2:0] rise_q;
    logic [7:0] breath_q;
    logic       to_bright_q;
    logic [7:0] presc_cnt_q;
    logic [7:0] duty_w;
    logic [7:0] duty_r;
    logic [7:0] duty_g;
    logic [7:0] duty_b;
    t_result    expected_q [$];

    function automatic void advance_color_wheel();
        for (int c = 0; c < 3; c++) begin
            if (fall_q[c]) begin
                wheel_lvl[c] = wheel_lvl[c] - 8'd1;
                if (wheel_lvl[c] == LEVEL_FULL) begin
                    fall_q[c] = 1'b0;
                    fall_q[(c + 1) % 3] = 1'b1;
                    rise_q[(c + 2) % 3] = 1'b1;
                end
            end
        end
        for (int c = 0; c < 3; c++) begin
            if (rise_q[c]) begin
                wheel_lvl[c] = wheel_lvl[c] + 8'd1;
                if (wheel_lvl[c] == LEVEL_OFF) begin
                    rise_q[c] = 1'b0;
                    rise_q[(c + 1) % 3] = 1'b1;
                end
            end
        end
        duty_r = wheel_lvl[COL_R];
        duty_g = wheel_lvl[COL_G];
        duty_b = wheel_lvl[COL_B];
    endfunction

    function automatic t_result predict_tick(input t_item tk);
        t_result r;
        r.dwell_us = (mode_q == MODE_FADE_FAST) ? cfg_q.fast_dwell_us : cfg_q.slow_dwell_us;
        case (mode_q)
            MODE_FADE_SLOW, MODE_FADE_FAST: begin
                if (presc_cnt_q >= cfg_q.prescale) begin
                    presc_cnt_q = 8'd0;
                    if (to_bright_q) begin
                        breath_q = breath_q - 8'd1;
                        if (breath_q <= cfg_q.bright_limit) begin
                            breath_q    = cfg_q.bright_limit;
                            to_bright_q = 1'b0;
                        end
                    end else begin
                        breath_q = breath_q + 8'd1;
                        if (breath_q >= cfg_q.dim_limit) begin
                            breath_q    = cfg_q.dim_limit;
                            to_bright_q = 1'b1;
                        end
                    end
                    duty_w = breath_q;
                end else begin
                    presc_cnt_q = presc_cnt_q + 8'd1;
                end
                advance_color_wheel();
            end
            MODE_POTS: begin
                duty_w = tk.pot_system;
                duty_r = tk.pot_red;
                duty_g = tk.pot_green;
                duty_b = tk.pot_blue;
            end
            default: begin
                duty_w = tk.pot_system;
                advance_color_wheel();
            end
        endcase
        if (tk.mode_press)
            mode_q = t_mode'(2'(mode_q + 2'd1));
        r.white_duty = duty_w;
        r.red_duty   = duty_r;
        r.green_duty = duty_g;
        r.blue_duty  = duty_b;
        r.mode_now   = mode_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg_q.bright_limit  = RST_BRIGHT_LIMIT;
            cfg_q.dim_limit     = RST_DIM_LIMIT;
            cfg_q.prescale      = RST_PRESCALE;
            cfg_q.slow_dwell_us = RST_SLOW_DWELL;
            cfg_q.fast_dwell_us = RST_FAST_DWELL;
            mode_q      = MODE_FADE_SLOW;
            wheel_lvl   = '{LEVEL_OFF, LEVEL_OFF, LEVEL_OFF};
            fall_q      = 3'b001 << COL_R;
            rise_q      = 3'b001 << COL_B;
            breath_q    = LEVEL_OFF;
            to_bright_q = 1'b1;
            presc_cnt_q = 8'd0;
            duty_w      = LEVEL_OFF;
            duty_r      = LEVEL_OFF;
            duty_g      = LEVEL_OFF;
            duty_b      = LEVEL_OFF;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BRIGHT_LIMIT: cfg_q.bright_limit  = i_cfg_data[7:0];
                    CFG_DIM_LIMIT:    cfg_q.dim_limit     = i_cfg_data[7:0];
                    CFG_PRESCALE:     cfg_q.prescale      = i_cfg_data[7:0];
                    CFG_SLOW_DWELL:   cfg_q.slow_dwell_us = i_cfg_data;
                    CFG_FAST_DWELL:   cfg_q.fast_dwell_us = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: result beat with no tick outstanding", $realtime);
                end else begin
                    want = expected_q.pop_front();
                    if (i_res.white_duty !== want.white_duty || i_res.red_duty !== want.red_duty
                        || i_res.green_duty !== want.green_duty
                        || i_res.blue_duty !== want.blue_duty
                        || i_res.mode_now !== want.mode_now
                        || i_res.dwell_us !== want.dwell_us) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $write("%0t: mismatch exp w=%h r=%h g=%h b=%h mode=%0d dwell=%0d",
                                   $realtime, want.white_duty, want.red_duty,
                                   want.green_duty, want.blue_duty, want.mode_now,
                                   want.dwell_us);
                            $display(" | got w=%h r=%h g=%h b=%h mode=%0d dwell=%0d",
                                     i_res.white_duty, i_res.red_duty,
                                     i_res.green_duty, i_res.blue_duty, i_res.mode_now,
                                     i_res.dwell_us);
                        end
                    end
                end
            end
            if (i_tick_valid && i_tick_ready)
                expected_q.push_back(predict_tick(i_tick));
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== bench/tb_rgb_and_breathing_led_sweeper.sv =====
// Testbench top: drives ticks, results backpressure and register writes for the LED sweeper.
`timescale 1ns / 100ps
module tb_rgb_and_breathing_led_sweeper;
    import rgbs_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    tx_idle_pct = 12;
    int                    rx_idle_pct = 67;
    int                    hold_asks   = 0;
    int                    items_sent  = 0;
    int                    loads_done  = 0;

    rgbs_in_if  tick_ch ();
    rgbs_out_if res_ch ();

    rgb_and_breathing_led_sweeper dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (tick_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rgbs_sweep_checker u_sweep_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_tick_valid (tick_ch.valid),
        .i_tick_ready (tick_ch.ready),
        .i_tick       (tick_ch.data),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res        (res_ch.data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic t_item mk_tick(input logic press, input logic [7:0] r,
                                      input logic [7:0] g, input logic [7:0] b,
                                      input logic [7:0] s);
        return {press, r, g, b, s};
    endfunction

    function automatic t_item rand_tick(input int press_pct);
        return mk_tick($urandom_range(99) < press_pct, 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
    endfunction

    task automatic send_tick(input t_item tk);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= tk;
        do @(posedge clk); while (!tick_ch.ready);
        items_sent++;
        if (items_sent < 450) begin
            tx_idle_pct = 12;
            rx_idle_pct = 67;
        end else if (items_sent < 900) begin
            tx_idle_pct = 67;
            rx_idle_pct = 12;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
    endtask

    task automatic load_settings(input logic [7:0] bright, input logic [7:0] dim,
                                 input logic [7:0] presc, input logic [15:0] slow,
                                 input logic [15:0] fast);
        wait_idle();
        write_reg(CFG_IDX_W'(CFG_FAST_DWELL + 1 + loads_done % 3), 16'($urandom));
        write_reg(CFG_BRIGHT_LIMIT, {8'($urandom), bright});
        write_reg(CFG_DIM_LIMIT, {8'($urandom), dim});
        write_reg(CFG_PRESCALE, {8'($urandom), presc});
        write_reg(CFG_SLOW_DWELL, slow);
        write_reg(CFG_FAST_DWELL, fast);
        @(negedge clk);
        cfg_we <= 1'b0;
        loads_done++;
    endtask

    task automatic run_batch(input int n);
        for (int i = 0; i < n; i++) begin
            if (items_sent == 600 || items_sent == 1050)
                hold_asks++;
            if (items_sent == 750)
                wait_idle();
            if ($urandom_range(99) < 85)
                send_tick(rand_tick(2));
            else
                send_tick(rand_tick(50));
        end
    endtask

    initial begin : result_sink
        int held;
        int holds_served;
        held         = 0;
        holds_served = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_served != hold_asks) begin
                holds_served = hold_asks;
                held         = HOLD_CYCLES;
            end
            if (held > 0) begin
                held--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        rst_n         = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.data  = '0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        send_tick(mk_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_tick(mk_tick(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_tick(mk_tick(1'b1, 8'hAA, 8'h55, 8'hAA, 8'h55));
        send_tick(mk_tick(1'b0, 8'h55, 8'hAA, 8'h55, 8'hAA));
        send_tick(mk_tick(1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF));
        send_tick(mk_tick(1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
        send_tick(mk_tick(1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00));
        send_tick(mk_tick(1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF));
        send_tick(mk_tick(1'b0, 8'h12, 8'h34, 8'h56, 8'h78));
        send_tick(mk_tick(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_tick(mk_tick(1'b0, 8'h9A, 8'hBC, 8'hDE, 8'hF0));
        send_tick(mk_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_tick(mk_tick(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_tick(mk_tick(1'b1, 8'h01, 8'h02, 8'h04, 8'h08));
        for (int i = 0; i < 6; i++)
            send_tick(mk_tick(1'b0, 8'h80, 8'h40, 8'h20, 8'h10));

        load_settings(8'h00, 8'hFF, 8'd0, 16'h0000, 16'hFFFF);
        run_batch(150);
        load_settings(8'd120, 8'd130, 8'd0, 16'hFFFF, 16'h0000);
        run_batch(150);
        load_settings(8'd200, 8'd50, 8'd1, 16'($urandom), 16'($urandom));
        run_batch(150);
        load_settings(8'hFF, 8'h00, 8'd254, 16'($urandom), 16'($urandom));
        run_batch(100);
        for (int k = 0; k < 3; k++) begin
            load_settings(8'($urandom), 8'($urandom), 8'($urandom_range(7)),
                          16'($urandom), 16'($urandom));
            run_batch(160);
        end
        load_settings(RST_BRIGHT_LIMIT, RST_DIM_LIMIT, RST_PRESCALE, RST_SLOW_DWELL,
                      RST_FAST_DWELL);
        run_batch(300);

        wait_idle();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rgbs_pkg.sv
rtl/rgbs_in_if.sv
rtl/rgbs_out_if.sv
rtl/rgbs_step.sv
rtl/rgb_and_breathing_led_sweeper.sv
rtl/rgbs_checker.sv
bench/rgbs_sweep_checker.sv
bench/tb_rgb_and_breathing_led_sweeper.sv
